@@ rtl/marching_squares_contour_unit_assert.svh @@
// assertion macros
`ifndef MARCHING_SQUARES_CONTOUR_UNIT_ASSERT_SVH
`define MARCHING_SQUARES_CONTOUR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define MSC_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MSC_ASSERT(label, clk, rst_n, prop)
`define MSC_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/msc_pkg.sv @@
`timescale 1ns / 1ps
package msc_pkg;
	localparam int SAMPLE_W = 16;
	localparam int COORD_W = 27;
	localparam int DIM_W = 11;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LEVEL = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic last;
	} seg_t;
endpackage

@@ rtl/msc_divider.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle: (num << FB) / den
module msc_divider #(
	parameter int FB = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] num,
	input logic [15:0] den,
	output logic busy,
	output logic [16+FB-1:0] quot
);
	localparam int QW = 16 + FB;
	localparam int CW = $clog2(QW + 1);
	logic [QW-1:0] dvd_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [16:0] trial;
	logic [16:0] sub;

	assign trial = {rem_q[15:0], dvd_q[QW-1]};
	assign sub = trial - {1'b0, den_q};
	assign busy = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, {FB{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (!sub[16]) begin
				rem_q <= sub;
				dvd_q <= {dvd_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				dvd_q <= {dvd_q[QW-2:0], 1'b0};
			end
		end
	end

	assign quot = dvd_q;
endmodule

@@ rtl/msc_line_store.sv @@
`timescale 1ns / 1ps
// previous-row store, single address port shared by read and write, registered read
module msc_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input logic clk,
	input logic rd_en,
	input logic wr_en,
	input logic [AW-1:0] addr,
	input logic [15:0] wdata,
	output logic [15:0] rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end
endmodule

@@ rtl/marching_squares_contour_unit.sv @@
`timescale 1ns / 1ps
// Marching squares contour unit, one iso level per pass.
// A word is taken only in the idle state, so the next word waits until the last is done.
// A word outside a cell (first row or column) goes from read straight to emit; a closed cell
// runs one serial division per crossing edge on the shared divider, then emits its
// segments, and waits longer while the output stalls.
// Reset: arst_n clears counters, left samples and registers; line store is not cleared.
module marching_squares_contour_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int FRACTION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // height_sample
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [111:0] m_axis_tdata, // start_x, start_y, end_x, end_y, pad
	output logic m_axis_tlast, // last_segment
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import msc_pkg::*;
	`include "marching_squares_contour_unit_assert.svh"

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int QW = 16 + FRACTION_BITS;
	localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRACTION_BITS;

	logic [DIM_W-1:0] width_q, height_q;
	logic [15:0] level_q;
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [15:0] lu_q, ll_q, s_q, up_q;
	state_t st_q;
	logic [2:0] edge_q;
	logic div_run_q;
	logic [COORD_W-1:0] px_q [4];
	logic [COORD_W-1:0] py_q [4];
	logic [2:0] pc_q;
	logic saddle_hi_q;
	logic seg_idx_q;
	seg_t out_q;
	logic ovalid_q;

	// register port
	logic wr;
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
			level_q <= 16'd32768;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_WIDTH: width_q <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_LEVEL: level_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH: prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_LEVEL: prdata = 32'(level_q);
			default: prdata = '0;
		endcase
	end

	logic [13:0] w_sat, h_sat;
	always_comb begin
		w_sat = 14'(width_q);
		if (w_sat < 14'd2) w_sat = 14'd2;
		if (w_sat > 14'(MAX_WIDTH)) w_sat = 14'(MAX_WIDTH);
		h_sat = 14'(height_q);
		if (h_sat < 14'd2) h_sat = 14'd2;
		if (h_sat > 14'(MAX_HEIGHT)) h_sat = 14'(MAX_HEIGHT);
	end

	logic acc;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;

	logic [15:0] mem_rd;
	msc_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_store (
		.clk(clk), .rd_en(acc), .wr_en(st_q == ST_READ),
		.addr(col_q), .wdata(s_q), .rdata(mem_rd)
	);

	// edge corners: top (lu,up) right (up,s) bottom (s,ll) left (ll,lu)
	logic [15:0] ea, eb;
	always_comb begin
		case (edge_q[1:0])
			2'd0: begin ea = lu_q; eb = up_q; end
			2'd1: begin ea = up_q; eb = s_q; end
			2'd2: begin ea = s_q; eb = ll_q; end
			default: begin ea = ll_q; eb = lu_q; end
		endcase
	end
	logic edge_cross;
	logic [15:0] dnum, dden;
	assign edge_cross = (ea >= level_q) != (eb >= level_q);
	assign dnum = (ea > level_q) ? ea - level_q : level_q - ea;
	assign dden = (ea > eb) ? ea - eb : eb - ea;

	logic div_start, div_busy;
	logic [QW-1:0] quot;
	msc_divider #(.FB(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(dnum), .den(dden),
		.busy(div_busy), .quot(quot)
	);

	logic closes_cell;
	logic [COORD_W-1:0] x0, y0, t;
	logic [17:0] csum;
	logic [17:0] lvl4;
	assign closes_cell = (row_q != '0) && (col_q != '0);
	assign x0 = COORD_W'(col_q - 1'b1) << FRACTION_BITS;
	assign y0 = COORD_W'(row_q - 1'b1) << FRACTION_BITS;
	assign t = COORD_W'(quot);
	assign csum = 18'(lu_q) + 18'(up_q) + 18'(s_q) + 18'(ll_q);
	assign lvl4 = {level_q, 2'b00};

	assign div_start = (st_q == ST_DIV) && !div_busy && !div_run_q && !edge_q[2] && edge_cross;

	logic seg_load;
	assign seg_load = (st_q == ST_EMIT) && ((pc_q == 3'd2) || (pc_q == 3'd4)) &&
		(!ovalid_q || m_axis_tready);

	logic [1:0] ia, ib;
	always_comb begin
		ia = 2'd0; ib = 2'd1;
		if (pc_q == 3'd4) begin
			if (saddle_hi_q) begin
				ia = seg_idx_q ? 2'd2 : 2'd0;
				ib = seg_idx_q ? 2'd3 : 2'd1;
			end else begin
				ia = seg_idx_q ? 2'd1 : 2'd0;
				ib = seg_idx_q ? 2'd2 : 2'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (seg_load) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			lu_q <= '0;
			ll_q <= '0;
			edge_q <= '0;
			div_run_q <= 1'b0;
			pc_q <= '0;
			seg_idx_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						s_q <= s_axis_tdata;
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					up_q <= mem_rd;
					edge_q <= '0;
					pc_q <= '0;
					div_run_q <= 1'b0;
					st_q <= closes_cell ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (edge_q[2]) begin
						saddle_hi_q <= csum >= lvl4;
						seg_idx_q <= 1'b0;
						st_q <= ST_EMIT;
					end else if (!edge_cross) begin
						edge_q <= edge_q + 1'b1;
					end else if (div_start) begin
						div_run_q <= 1'b1;
					end else if (div_run_q && !div_busy) begin
						div_run_q <= 1'b0;
						case (edge_q[1:0])
							2'd0: begin px_q[pc_q[1:0]] <= x0 + t; py_q[pc_q[1:0]] <= y0; end
							2'd1: begin px_q[pc_q[1:0]] <= x0 + ONE;
								py_q[pc_q[1:0]] <= y0 + t; end
							2'd2: begin px_q[pc_q[1:0]] <= x0 + ONE - t;
								py_q[pc_q[1:0]] <= y0 + ONE; end
							default: begin px_q[pc_q[1:0]] <= x0;
								py_q[pc_q[1:0]] <= y0 + ONE - t; end
						endcase
						pc_q <= pc_q + 1'b1;
						edge_q <= edge_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (pc_q != 3'd2 && pc_q != 3'd4) begin
						lu_q <= up_q;
						ll_q <= s_q;
						if (14'(col_q) + 14'd1 >= w_sat) begin
							col_q <= '0;
							row_q <= (14'(row_q) + 14'd1 >= h_sat) ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						st_q <= ST_IDLE;
					end else if (seg_load) begin
						out_q.sx <= px_q[ia];
						out_q.sy <= py_q[ia];
						out_q.ex <= px_q[ib];
						out_q.ey <= py_q[ib];
						out_q.last <= (pc_q == 3'd2) || seg_idx_q;
						if (pc_q == 3'd2 || seg_idx_q) pc_q <= '0;
						else seg_idx_q <= 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {4'd0, out_q.ey, out_q.ex, out_q.sy, out_q.sx};
	assign m_axis_tlast = out_q.last;

	`MSC_ASSERT(a_onehot, clk, arst_n, $onehot(st_q))
	`MSC_ASSERT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	`MSC_ASSERT(a_pc, clk, arst_n, pc_q <= 3'd4)
	`MSC_ASSERT(a_noacc, clk, arst_n, st_q != ST_IDLE |-> !s_axis_tready)
endmodule

@@ tb/sv/tb_marching_squares_contour_unit.sv @@
`timescale 1ns / 1ps
module tb_marching_squares_contour_unit;
	import msc_pkg::*;

	localparam int FRAC = 16;
	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int SETTLE = 200;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata; // height_sample
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [111:0] m_axis_tdata; // start_x, start_y, end_x, end_y, pad
	logic m_axis_tlast; // last_segment
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	marching_squares_contour_unit dut (.*);

	// model state
	logic [15:0] line_mem [MAXW];
	logic [15:0] ul_sample, ll_sample;
	int unsigned col_cnt, row_cnt;
	logic [10:0] width_reg, height_reg;
	logic [15:0] level_reg;

	seg_t seg_q[$];
	int err_cnt;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
		end
	end

	task automatic report(input string what);
		err_cnt++;
		$display("ERROR @%0t: %s", $realtime, what);
	endtask

	// segment checker
	always @(posedge clk) begin
		seg_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.sx = m_axis_tdata[26:0];
			got.sy = m_axis_tdata[53:27];
			got.ex = m_axis_tdata[80:54];
			got.ey = m_axis_tdata[107:81];
			got.last = m_axis_tlast;
			if (seg_q.size() == 0) begin
				report($sformatf("unexpected segment %h", m_axis_tdata));
			end else begin
				want = seg_q.pop_front();
				if (got.sx !== want.sx) report($sformatf("start_x %h exp %h", got.sx, want.sx));
				if (got.sy !== want.sy) report($sformatf("start_y %h exp %h", got.sy, want.sy));
				if (got.ex !== want.ex) report($sformatf("end_x %h exp %h", got.ex, want.ex));
				if (got.ey !== want.ey) report($sformatf("end_y %h exp %h", got.ey, want.ey));
				if (got.last !== want.last) report($sformatf("last %b exp %b", got.last, want.last));
			end
		end
	end

	function automatic longint unsigned edge_frac(int unsigned a, int unsigned b,
			int unsigned lvl);
		longint unsigned num, den;
		num = (a > lvl) ? a - lvl : lvl - a;
		den = (a > b) ? a - b : b - a;
		if (den == 0) return 0;
		return (num << FRAC) / den;
	endfunction

	function automatic bit crossing(int unsigned a, int unsigned b, int unsigned lvl);
		return (a >= lvl) != (b >= lvl);
	endfunction

	function automatic seg_t make_seg(longint unsigned x0, longint unsigned y0,
			longint unsigned x1, longint unsigned y1);
		seg_t s;
		s.sx = x0[COORD_W-1:0];
		s.sy = y0[COORD_W-1:0];
		s.ex = x1[COORD_W-1:0];
		s.ey = y1[COORD_W-1:0];
		s.last = 1'b0;
		return s;
	endfunction

	task automatic queue_seg(input seg_t s);
		seg_q = {seg_q, s};
	endtask

	// advance model by one sample, queue the segments it closes
	task automatic predict_cell(input logic [15:0] smp);
		int unsigned w, h, c, r, lvl, upper, h00, h10, h01, h11;
		longint unsigned x0, y0, one;
		longint unsigned px[4], py[4];
		int pc;
		seg_t s0, s1;
		w = width_reg; h = height_reg;
		if (w < 2) w = 2;
		if (w > MAXW) w = MAXW;
		if (h < 2) h = 2;
		if (h > MAXH) h = MAXH;
		c = (col_cnt >= MAXW) ? MAXW - 1 : col_cnt;
		r = row_cnt;
		lvl = level_reg;
		upper = line_mem[c];
		line_mem[c] = smp;
		pc = 0;
		if (r >= 1 && c >= 1) begin
			h00 = ul_sample; h10 = upper; h01 = ll_sample; h11 = smp;
			x0 = longint'(c - 1) << FRAC;
			y0 = longint'(r - 1) << FRAC;
			one = 64'd1 << FRAC;
			if (crossing(h00, h10, lvl)) begin
				px[pc] = x0 + edge_frac(h00, h10, lvl); py[pc] = y0; pc++;
			end
			if (crossing(h10, h11, lvl)) begin
				px[pc] = x0 + one; py[pc] = y0 + edge_frac(h10, h11, lvl); pc++;
			end
			if (crossing(h11, h01, lvl)) begin
				px[pc] = x0 + one - edge_frac(h11, h01, lvl); py[pc] = y0 + one; pc++;
			end
			if (crossing(h01, h00, lvl)) begin
				px[pc] = x0; py[pc] = y0 + one - edge_frac(h01, h00, lvl); pc++;
			end
			if (pc == 2) begin
				s0 = make_seg(px[0], py[0], px[1], py[1]);
				s0.last = 1'b1;
				queue_seg(s0);
			end else if (pc == 4) begin
				// saddle: corner sum against four times the level picks the pairing
				if (h00 + h10 + h11 + h01 >= 4 * lvl) begin
					s0 = make_seg(px[0], py[0], px[1], py[1]);
					s1 = make_seg(px[2], py[2], px[3], py[3]);
				end else begin
					s0 = make_seg(px[0], py[0], px[3], py[3]);
					s1 = make_seg(px[1], py[1], px[2], py[2]);
				end
				s1.last = 1'b1;
				queue_seg(s0);
				queue_seg(s1);
			end
		end
		ul_sample = upper[15:0];
		ll_sample = smp;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	task automatic send_word(input logic [15:0] smp);
		if (!calm && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		do @(posedge clk); while (!s_axis_tready);
		predict_cell(smp);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (seg_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_WIDTH: width_reg = val[10:0];
			REG_HEIGHT: height_reg = val[10:0];
			REG_LEVEL: level_reg = val[15:0];
			default: ;
		endcase
	endtask

	function automatic logic [15:0] near_level(input logic [15:0] lvl);
		int v;
		if ($urandom_range(99) < 40) return 16'($urandom_range(65535));
		v = int'(lvl) + int'($urandom_range(4000)) - 2000;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[15:0];
	endfunction

	task automatic frame_of(input int w, input int h, input int mode);
		for (int i = 0; i < w * h; i++) begin
			case (mode)
				0: send_word(near_level(level_reg));
				1: send_word($urandom_range(1) ? 16'hFFFF : 16'h0000);
				default: send_word(16'($urandom_range(65535)));
			endcase
		end
	endtask

	task automatic test_saddles();
		logic [15:0] pix [9] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000};
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 3);
		write_reg(REG_LEVEL, 32'h8000);
		foreach (pix[i]) send_word(pix[i]);
		write_reg(REG_LEVEL, 32'h7FFF);
		foreach (pix[i]) send_word(pix[i]);
	endtask

	task automatic test_level_extremes();
		write_reg(REG_WIDTH, 2);
		write_reg(REG_HEIGHT, 2);
		write_reg(REG_LEVEL, 0);
		frame_of(2, 2, 1);
		write_reg(REG_LEVEL, 32'hFFFF);
		frame_of(2, 2, 1);
		write_reg(REG_LEVEL, 1);
		frame_of(2, 2, 1);
	endtask

	task automatic test_saturation();
		// widths and heights outside the legal range clamp
		write_reg(REG_WIDTH, 1);
		write_reg(REG_HEIGHT, 0);
		write_reg(REG_LEVEL, $urandom_range(65535));
		frame_of(2, 2, 2);
		write_reg(REG_WIDTH, 32'h7FF);
		write_reg(REG_HEIGHT, 1);
		write_reg(REG_LEVEL, 32'hF000);
		// one full clamped row, then the first cells of the next
		for (int i = 0; i < MAXW + 2; i++) send_word(near_level(level_reg));
	endtask

	task automatic test_random_frames();
		int w, h, sent, frame_no;
		sent = 0;
		frame_no = 0;
		while (sent < 100) begin
			w = $urandom_range(12, 2);
			h = $urandom_range(6, 2);
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			write_reg(REG_LEVEL, $urandom_range(65535));
			calm = (frame_no == 1);
			frame_of(w, h, (sent % 7 == 0) ? 2 : 0);
			sent += w * h;
			frame_no++;
		end
		calm = 1'b0;
	endtask

	initial begin
		int guard;
		err_cnt = 0;
		calm = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		foreach (line_mem[i]) line_mem[i] = '0;
		ul_sample = '0; ll_sample = '0; col_cnt = 0; row_cnt = 0;
		width_reg = 11'd1024; height_reg = 11'd1024; level_reg = 16'h8000;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_saddles();
		test_level_extremes();
		test_saturation();
		test_random_frames();
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (seg_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0 && seg_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#8ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
